>>> sv/ssdd_pkg.sv
// ----------------------------------------------------------------------------
// ssdd_pkg
// Shared types, constants and the segment table of the seven-segment
// serial display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdd_pkg;

  localparam int VALUE_W    = 32;
  localparam int QUOT_W     = 29;  // floor((2**32-1)/10) fits in 29 bits
  localparam int FRAME_BITS = 16;

  // floor(x/10) == (x * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit x
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [7:0] SEL_MASK = 8'hFF;
  localparam logic [7:0] DOT_BIT  = 8'h80;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  digit_count;
    logic [7:0]  dot_mask;
  } ssdd_in_t;

  typedef struct packed {
    logic       serial_bit;
    logic       latch;
    logic [1:0] digit_index;
    logic       last;
  } ssdd_out_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'b0011_1111;
      4'd1:    pat = 8'b0000_0110;
      4'd2:    pat = 8'b0101_1011;
      4'd3:    pat = 8'b0100_1111;
      4'd4:    pat = 8'b0110_0110;
      4'd5:    pat = 8'b0110_1101;
      4'd6:    pat = 8'b0111_1101;
      4'd7:    pat = 8'b0000_0111;
      4'd8:    pat = 8'b0111_1111;
      4'd9:    pat = 8'b0110_1111;
      default: pat = 8'b0000_0000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> sv/ssdd_div10.sv
// ----------------------------------------------------------------------------
// ssdd_div10
// Shared divide-by-ten unit: reciprocal multiply into a registered quotient,
// remainder recovered the following cycle from the held dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdd_div10
  import ssdd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [VALUE_W-1:0] dividend,
  output logic      [QUOT_W-1:0]  quot,
  output logic      [3:0]         rem
);

  logic [63:0]       prod;
  logic [QUOT_W-1:0] quot_r;
  logic [QUOT_W-1:0] quot_nxt;
  logic [VALUE_W-1:0] times10;

  assign prod     = 64'(dividend) * 64'(DIV10_MAGIC);
  assign quot_nxt = prod[DIV10_SHIFT +: QUOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= quot_nxt;
    end
  end

  // dividend is held stable until the remainder is taken
  assign times10 = (VALUE_W'(quot_r) << 3) + (VALUE_W'(quot_r) << 1);
  assign rem     = 4'(dividend - times10);
  assign quot    = quot_r;

endmodule

`default_nettype wire

>>> sv/seven_segment_serial_display_driver_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_unit
// Splits a value into decimal digits and streams one 16-bit select/segment
// frame per digit, MSB first, for a chain of serial-in shift registers.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the item is taken on an edge where busy is
//   low. busy stays high while the item is converted and streamed.
//   n = min(digit_count, NUM_DIGITS). Conversion uses one shared divide-by-10
//   unit, a multiply step and then a remainder step for each of the n digits.
//   Each digit then sends 16 beats, one per cycle, on out_strobe/out_data;
//   latch marks the sixteenth beat of a frame, last the final beat of the item.
//   The beats follow the conversion; the final beat is on the ports from the
//   same edge at which busy drops, and only then can the next item be taken.
//   A count of zero gives no beats and the block is ready again the next cycle.
//   The receiver takes every beat as it comes; there is no backpressure.
//   Reset (rst_n low, synchronous) returns to idle and drops out_strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_display_driver_unit
  import ssdd_pkg::*;
#(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire ssdd_in_t  in_data,
  output logic           out_strobe,
  output ssdd_out_t      out_data
);

  localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_REM  = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [NUM_DIGITS-1:0] dots_r, dots_nxt;
  logic [DW-1:0]         d_r, d_nxt;
  logic [DW-1:0]         last_d_r, last_d_nxt;
  logic [3:0]            b_r, b_nxt;
  logic [3:0]            digit_r   [NUM_DIGITS];
  logic [3:0]            digit_nxt [NUM_DIGITS];
  logic                  out_strobe_r, out_strobe_nxt;
  ssdd_out_t             out_r, out_nxt;

  logic                  accept;
  logic [3:0]            cnt_sat;
  logic [QUOT_W-1:0]     quot;
  logic [3:0]            rem;
  logic [7:0]            sel_byte;
  logic [7:0]            seg_byte;
  logic [FRAME_BITS-1:0] frame;
  logic                  frame_end;
  logic                  item_end;

  ssdd_div10 u_div10 (
    .clk      (clk),
    .en       (state_r == ST_MUL),
    .dividend (val_r),
    .quot     (quot),
    .rem      (rem)
  );

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign cnt_sat = (in_data.digit_count > 4'(NUM_DIGITS)) ? 4'(NUM_DIGITS)
                                                          : in_data.digit_count;

  assign sel_byte  = SEL_MASK & ~(8'd1 << d_r);
  assign seg_byte  = seg_pattern(digit_r[d_r]) | (dots_r[d_r] ? DOT_BIT : 8'h00);
  assign frame     = {sel_byte, seg_byte};
  assign frame_end = (b_r == 4'(FRAME_BITS - 1));
  assign item_end  = frame_end && (d_r == last_d_r);

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    dots_nxt       = dots_r;
    d_nxt          = d_r;
    last_d_nxt     = last_d_r;
    b_nxt          = b_r;
    digit_nxt      = digit_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt    = in_data.value;
          dots_nxt   = in_data.dot_mask[NUM_DIGITS-1:0];
          d_nxt      = '0;
          last_d_nxt = DW'(cnt_sat - 4'd1);
          if (cnt_sat != 4'd0) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_REM;
      end
      ST_REM: begin
        digit_nxt[d_r] = rem;
        val_nxt        = VALUE_W'(quot);
        if (d_r == last_d_r) begin
          d_nxt     = '0;
          b_nxt     = '0;
          state_nxt = ST_SEND;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_SEND: begin
        out_strobe_nxt      = 1'b1;
        out_nxt.serial_bit  = frame[4'(FRAME_BITS - 1) - b_r];
        out_nxt.latch       = frame_end;
        out_nxt.digit_index = 2'(d_r);
        out_nxt.last        = item_end;
        b_nxt               = b_r + 4'd1;
        if (frame_end) begin
          b_nxt = '0;
          if (item_end) begin
            state_nxt = ST_IDLE;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    dots_r   <= dots_nxt;
    d_r      <= d_nxt;
    last_d_r <= last_d_nxt;
    b_r      <= b_nxt;
    digit_r  <= digit_nxt;
    out_r    <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef NO_ASSERTIONS
  // every beat comes from work started earlier
  a_beat_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("beat without work in flight");

  // the final beat of an item closes a frame
  a_last_is_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last |-> out_data.latch)
    else $error("last beat not on frame end");

  // a frame streams without gaps
  a_frame_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.latch |=> out_strobe)
    else $error("gap inside a frame");

  // a nonzero count starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.digit_count != 4'd0) |=> busy)
    else $error("accepted item did not start");
`endif

endmodule

`default_nettype wire

>>> tb/seven_segment_serial_display_driver_unit_checker.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_unit_checker
// Watches the command and beat channels of the display driver. It works out
// the serial frames of every accepted value and compares each beat, field by
// field, with the oldest expected one. It hands the failure count and the
// number of beats still expected to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_display_driver_unit_checker
  import ssdd_pkg::*;
#(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire ssdd_in_t  in_data,
  input  wire logic      out_strobe,
  input  wire ssdd_out_t out_data,
  input  wire logic      drained,
  output int             fail_count,
  output int             beats_pending
);

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  ssdd_out_t expected_beats [$];
  int        errors = 0;
  logic      leftovers_checked = 1'b0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // one 16-beat frame per shown digit, least significant digit first
  task automatic queue_frames(input ssdd_in_t cmd);
    int          shown;
    logic [31:0] rest;
    logic [3:0]  digit;
    logic [7:0]  seg;
    logic [7:0]  sel;
    logic [15:0] frame;
    ssdd_out_t   beat;
    shown = (cmd.digit_count > NUM_DIGITS) ? NUM_DIGITS : int'(cmd.digit_count);
    rest  = cmd.value;
    for (int d = 0; d < shown; d++) begin
      digit = 4'(rest % 10);
      rest  = rest / 10;
      seg   = SEG_TABLE[digit];
      if (cmd.dot_mask[d]) seg = seg | DOT_BIT;
      sel   = SEL_MASK & ~(8'h01 << d);
      frame = {sel, seg};
      for (int b = 0; b < FRAME_BITS; b++) begin
        beat.serial_bit  = frame[FRAME_BITS - 1 - b];
        beat.latch       = (b == FRAME_BITS - 1);
        beat.digit_index = 2'(d);
        beat.last        = (b == FRAME_BITS - 1) && (d == shown - 1);
        expected_beats.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    ssdd_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %b", out_data));
        end else begin
          want = expected_beats.pop_front();
          if (out_data.serial_bit !== want.serial_bit)
            report_mismatch($sformatf("serial_bit %b, expected %b",
                                      out_data.serial_bit, want.serial_bit));
          if (out_data.latch !== want.latch)
            report_mismatch($sformatf("latch %b, expected %b",
                                      out_data.latch, want.latch));
          if (out_data.digit_index !== want.digit_index)
            report_mismatch($sformatf("digit_index %0d, expected %0d",
                                      out_data.digit_index, want.digit_index));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b",
                                      out_data.last, want.last));
        end
      end
      if (start && !busy) queue_frames(in_data);
      if (drained && !leftovers_checked) begin
        leftovers_checked <= 1'b1;
        if (expected_beats.size() != 0)
          report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
      end
    end
    beats_pending <= expected_beats.size();
  end

endmodule

`default_nettype wire

>>> tb/seven_segment_serial_display_driver_unit_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_unit_tb
// Drives the display driver with directed values (field extremes, digit
// counts of zero and above four, unused dot bits, leading zeros, every digit)
// and then random values in phases with and without idle gaps. A checker
// beside the block predicts every beat; this top only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_display_driver_unit_tb
  import ssdd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 480;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  ssdd_in_t  in_data = '0;
  logic      drained = 1'b0;
  logic      busy;
  logic      out_strobe;
  ssdd_out_t out_data;
  int        fail_count;
  int        beats_pending;
  int        cycle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_serial_display_driver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  seven_segment_serial_display_driver_unit_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_strobe   (out_strobe),
    .out_data     (out_data),
    .drained      (drained),
    .fail_count   (fail_count),
    .beats_pending(beats_pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // optional idle gap, then hold the command until the block takes it
  task automatic send_value(input ssdd_in_t cmd, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
  endtask

  function automatic ssdd_in_t random_value();
    ssdd_in_t cmd;
    case ($urandom_range(3))
      0:       cmd.value = $urandom;
      1:       cmd.value = $urandom_range(0, 9999);
      2:       cmd.value = $urandom_range(0, 99);
      default: cmd.value = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    endcase
    if ($urandom_range(99) < 70) cmd.digit_count = 4'($urandom_range(1, 4));
    else                         cmd.digit_count = 4'($urandom_range(0, 15));
    cmd.dot_mask = 8'($urandom_range(0, 255));
    return cmd;
  endfunction

  initial begin
    ssdd_in_t directed [$];
    int       idle_pcts [3];

    idle_pcts = '{0, 74, 20};
    directed = '{
      '{value: 32'd0,          digit_count: 4'd4,  dot_mask: 8'h00},
      '{value: 32'hFFFF_FFFF,  digit_count: 4'd4,  dot_mask: 8'hFF},
      '{value: 32'd3210,       digit_count: 4'd4,  dot_mask: 8'h05},
      '{value: 32'd7654,       digit_count: 4'd4,  dot_mask: 8'h0A},
      '{value: 32'd98,         digit_count: 4'd2,  dot_mask: 8'h03},
      '{value: 32'd7,          digit_count: 4'd4,  dot_mask: 8'h00},  // leading zeros
      '{value: 32'd1234,       digit_count: 4'd0,  dot_mask: 8'hFF},  // nothing shown
      '{value: 32'd5678,       digit_count: 4'd1,  dot_mask: 8'hFE},  // unused dots
      '{value: 32'd5678,       digit_count: 4'd3,  dot_mask: 8'hF8},
      '{value: 32'd99999,      digit_count: 4'd5,  dot_mask: 8'h10},  // saturates
      '{value: 32'd4294967295, digit_count: 4'd15, dot_mask: 8'hF0},
      '{value: 32'd1000,       digit_count: 4'd8,  dot_mask: 8'h08},
      '{value: 32'd0,          digit_count: 4'd0,  dot_mask: 8'h00},
      '{value: 32'd0,          digit_count: 4'd0,  dot_mask: 8'h00},
      '{value: 32'd8765,       digit_count: 4'd4,  dot_mask: 8'h0F},
      '{value: 32'h8000_0000,  digit_count: 4'd4,  dot_mask: 8'h00},
      '{value: 32'd9,          digit_count: 4'd1,  dot_mask: 8'h01}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i], 0);
    foreach (idle_pcts[p])
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_value(random_value(), idle_pcts[p]);
    start <= 1'b0;

    // an item that shows nothing gives no beat, so settle a little after the queue empties
    while (beats_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    drained <= 1'b1;
    repeat (3) @(posedge clk);

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
